[hw/rtl/nmeaps_pkg.sv]
package nmeaps_pkg;

	// Character codes the parser reacts to.
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	// Field widths of the byte and result words.
	localparam int BYTE_W    = 8;
	localparam int FIELD_W   = 5;
	localparam int FACTOR_W  = 16;
	localparam int LAT_W     = 30;
	localparam int LON_W     = 34;
	localparam int SPD_W     = 27;
	localparam int SPD_OUT_W = 33;

	// Accumulator limits and fraction digits kept per number.
	localparam logic [63:0] LAT_CAP = 64'd999999999;
	localparam logic [63:0] LON_CAP = 64'd9999999999;
	localparam logic [63:0] SPD_CAP = 64'd99999999;
	localparam int POS_SCALE = 5;
	localparam int SPD_SCALE = 3;

	// Highest field index; the comma count stops there.
	localparam logic [FIELD_W-1:0] FIELD_IDX_MAX = 5'd31;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_FIELD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LATITUDE_FIELD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONGITUDE_FIELD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FIELD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHAR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR    = 3'd5;
	localparam int CFG_DATA_W = 16;

	// Reciprocal of 125 for exact division of values below 2^24:
	// y / 125 == (y * RECIP_M) >> RECIP_SHIFT.
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP_M = 25'd17179870;
	localparam logic [9:0] MILLI_DIV = 10'd1000;

	// Result queue depth, a power of two.
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [FIELD_W-1:0]  status_field;
		logic [FIELD_W-1:0]  latitude_field;
		logic [FIELD_W-1:0]  longitude_field;
		logic [FIELD_W-1:0]  speed_field;
		logic [BYTE_W-1:0]   active_char;
		logic [FACTOR_W-1:0] speed_factor_milli;
	} cfg_t;

	// One finished sentence as handed from the parser to the scaler.
	typedef struct packed {
		logic             fix_active;
		logic [LAT_W-1:0] latitude_e5;
		logic [LON_W-1:0] longitude_e5;
		logic [SPD_W-1:0] speed_value;
	} entry_t;

	// Powers of ten up to 10^5.
	function automatic logic [16:0] pow10(input logic [2:0] k);
		logic [16:0] p;
		case (k)
			3'd0: p = 17'd1;
			3'd1: p = 17'd10;
			3'd2: p = 17'd100;
			3'd3: p = 17'd1000;
			3'd4: p = 17'd10000;
			3'd5: p = 17'd100000;
			default: p = 17'd1;
		endcase
		return p;
	endfunction

endpackage

[hw/rtl/nmeaps_if.sv]
// Byte channel into the parser.
interface nmeaps_byte_if import nmeaps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_sentence;

	modport source(output valid, output data_byte, output end_of_sentence, input ready);
	modport sink(input valid, input data_byte, input end_of_sentence, output ready);
endinterface

// Result channel out of the block.
interface nmeaps_result_if import nmeaps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 fix_active;
	logic [LAT_W-1:0]     latitude_e5;
	logic [LON_W-1:0]     longitude_e5;
	logic [SPD_OUT_W-1:0] speed_milli_kmh;

	modport source(output valid, output fix_active, output latitude_e5,
		output longitude_e5, output speed_milli_kmh, input ready);
	modport sink(input valid, input fix_active, input latitude_e5,
		input longitude_e5, input speed_milli_kmh, output ready);
endinterface

[hw/rtl/nmeaps_num.sv]
module nmeaps_num import nmeaps_pkg::*; #(
	parameter int VW = 30,
	parameter int CHARS = 10,
	parameter int SCALE = 5,
	parameter logic [63:0] CAP = 64'd999999999
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              take,
	input  logic [BYTE_W-1:0] ch,
	output logic [VW-1:0]     value
);

	localparam int CW = $clog2(CHARS + 1);
	localparam int FW = $clog2(SCALE + 1);
	localparam int WX = VW + 4;

	logic [VW-1:0] val_q, val_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [FW-1:0] frac_q, frac_d;
	logic          point_q, point_d;
	logic          stop_q, stop_d;

	logic          is_digit;
	logic [3:0]    digit;
	logic [2:0]    frac_pow;
	logic [WX-1:0] int_sum, frac_sum;
	logic [VW-1:0] int_val, frac_val;

	assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
	assign digit    = ch[3:0];
	assign frac_pow = 3'(SCALE - 1) - 3'(frac_q);

	// Integer digit shifts the value up a decade; a fraction digit adds at its weight.
	assign int_sum  = (WX'(val_q) << 3) + (WX'(val_q) << 1)
		+ WX'(digit) * WX'(pow10(3'(SCALE)));
	assign frac_sum = WX'(val_q) + WX'(digit) * WX'(pow10(frac_pow));
	assign int_val  = (int_sum > WX'(CAP)) ? VW'(CAP) : VW'(int_sum);
	assign frac_val = (frac_sum > WX'(CAP)) ? VW'(CAP) : VW'(frac_sum);

	// Number syntax: digits, one optional point, digits; anything else ends it.
	always_comb begin
		val_d   = val_q;
		cnt_d   = cnt_q;
		frac_d  = frac_q;
		point_d = point_q;
		stop_d  = stop_q;
		if (clear) begin
			val_d   = '0;
			cnt_d   = '0;
			frac_d  = '0;
			point_d = 1'b0;
			stop_d  = 1'b0;
		end else if (take && (cnt_q < CW'(CHARS))) begin
			cnt_d = cnt_q + 1'b1;
			if (!stop_q) begin
				if (is_digit) begin
					if (!point_q) begin
						val_d = int_val;
					end else if (frac_q < FW'(SCALE)) begin
						frac_d = frac_q + 1'b1;
						val_d  = frac_val;
					end
				end else if ((ch == CHAR_DOT) && !point_q) begin
					point_d = 1'b1;
				end else begin
					stop_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q   <= '0;
			cnt_q   <= '0;
			frac_q  <= '0;
			point_q <= 1'b0;
			stop_q  <= 1'b0;
		end else begin
			val_q   <= val_d;
			cnt_q   <= cnt_d;
			frac_q  <= frac_d;
			point_q <= point_d;
			stop_q  <= stop_d;
		end
	end

	assign value = val_d;

`ifndef ASSERT_OFF
	// The accumulator never passes its saturation limit.
	assert property (@(posedge clk) disable iff (!arst_n) WX'(val_q) <= WX'(CAP))
		else $error("number accumulator above its limit");

	// No more fraction digits are kept than the scale allows.
	assert property (@(posedge clk) disable iff (!arst_n)
		(frac_q <= FW'(SCALE)) && (!(frac_q != '0) || point_q))
		else $error("fraction digit count without a point or past scale");
`endif

endmodule

[hw/rtl/nmeaps_front.sv]
module nmeaps_front import nmeaps_pkg::*; #(
	parameter int SENTENCE_LEN = 70,
	parameter int LAT_CHARS = 10,
	parameter int LON_CHARS = 11,
	parameter int SPEED_CHARS = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	nmeaps_byte_if.sink  sentence,
	input  cfg_t         cfg,
	input  logic         queue_full,
	output logic         push,
	output entry_t       push_data
);

	localparam int BPW = $clog2(SENTENCE_LEN + 1);

	logic [FIELD_W-1:0] field_count_q, field_count_d;
	logic [BPW-1:0]     byte_pos_q, byte_pos_d;
	logic               active_q, active_d;

	logic               fire, is_dollar, is_comma, counted;
	logic               sel_status, sel_lat, sel_lon, sel_spd;
	logic               clear;
	logic [LAT_W-1:0]   lat_value;
	logic [LON_W-1:0]   lon_value;
	logic [SPD_W-1:0]   spd_value;

	assign sentence.ready = !queue_full;
	assign fire      = sentence.valid && sentence.ready;
	assign is_dollar = (sentence.data_byte == CHAR_DOLLAR);
	assign is_comma  = (sentence.data_byte == CHAR_COMMA);
	assign counted   = fire && !is_dollar && (byte_pos_q < BPW'(SENTENCE_LEN));
	assign clear     = fire && is_dollar;

	// Field routing; status wins over latitude, then longitude, then speed.
	always_comb begin
		sel_status = 1'b0;
		sel_lat    = 1'b0;
		sel_lon    = 1'b0;
		sel_spd    = 1'b0;
		if (counted && !is_comma) begin
			if (field_count_q == cfg.status_field) begin
				sel_status = 1'b1;
			end else if (field_count_q == cfg.latitude_field) begin
				sel_lat = 1'b1;
			end else if (field_count_q == cfg.longitude_field) begin
				sel_lon = 1'b1;
			end else if (field_count_q == cfg.speed_field) begin
				sel_spd = 1'b1;
			end
		end
	end

	// Sentence counters and the fix flag, which survives a restart.
	always_comb begin
		field_count_d = field_count_q;
		byte_pos_d    = byte_pos_q;
		active_d      = active_q;
		if (clear) begin
			field_count_d = '0;
			byte_pos_d    = '0;
		end else if (counted) begin
			byte_pos_d = byte_pos_q + 1'b1;
			if (is_comma && (field_count_q != FIELD_IDX_MAX)) begin
				field_count_d = field_count_q + 1'b1;
			end
		end
		if (sel_status) begin
			active_d = (sentence.data_byte == cfg.active_char);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q <= '0;
			byte_pos_q    <= '0;
			active_q      <= 1'b0;
		end else begin
			field_count_q <= field_count_d;
			byte_pos_q    <= byte_pos_d;
			active_q      <= active_d;
		end
	end

	nmeaps_num #(.VW(LAT_W), .CHARS(LAT_CHARS), .SCALE(POS_SCALE), .CAP(LAT_CAP)) u_lat (
		.clk(clk), .arst_n(arst_n), .clear(clear), .take(sel_lat),
		.ch(sentence.data_byte), .value(lat_value)
	);

	nmeaps_num #(.VW(LON_W), .CHARS(LON_CHARS), .SCALE(POS_SCALE), .CAP(LON_CAP)) u_lon (
		.clk(clk), .arst_n(arst_n), .clear(clear), .take(sel_lon),
		.ch(sentence.data_byte), .value(lon_value)
	);

	nmeaps_num #(.VW(SPD_W), .CHARS(SPEED_CHARS), .SCALE(SPD_SCALE), .CAP(SPD_CAP)) u_spd (
		.clk(clk), .arst_n(arst_n), .clear(clear), .take(sel_spd),
		.ch(sentence.data_byte), .value(spd_value)
	);

	// The last word of a sentence queues a snapshot of the updated state.
	assign push                   = fire && sentence.end_of_sentence;
	assign push_data.fix_active   = active_d;
	assign push_data.latitude_e5  = lat_value;
	assign push_data.longitude_e5 = lon_value;
	assign push_data.speed_value  = spd_value;

`ifndef ASSERT_OFF
	// The byte position stops at the sentence length limit.
	assert property (@(posedge clk) disable iff (!arst_n) byte_pos_q <= BPW'(SENTENCE_LEN))
		else $error("byte position past the sentence limit");
`endif

endmodule

[hw/rtl/nmeaps_fifo.sv]
module nmeaps_fifo import nmeaps_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   head_valid
);

	localparam int AW = $clog2(Q_DEPTH);
	localparam int NW = $clog2(Q_DEPTH + 1);

	entry_t         slots_q [Q_DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]  count_q;

	assign full       = (count_q == NW'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	// Neither overflow nor underflow can happen with the handshakes as wired.
	assert property (@(posedge clk) disable iff (!arst_n) (!(push && full)) && (!(pop && !head_valid)))
		else $error("result queue written when full or read when empty");

	// The fill level follows the pointer distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		full || (AW'(wr_ptr_q - rd_ptr_q) == AW'(count_q)))
		else $error("result queue pointers and level disagree");
`endif

endmodule

[hw/rtl/nmeaps_back.sv]
module nmeaps_back import nmeaps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  entry_t              head,
	input  logic                head_valid,
	input  logic [FACTOR_W-1:0] factor,
	output logic                pop,
	nmeaps_result_if.source     result
);

	localparam int MW  = 24 + RECIP_W;
	localparam int QW  = MW - RECIP_SHIFT;
	localparam int HW  = QW + FACTOR_W;
	localparam int LW  = 10 + FACTOR_W;
	localparam int L2W = (LW - 3) + RECIP_W;

	typedef struct packed {
		logic             fix_active;
		logic [LAT_W-1:0] latitude_e5;
		logic [LON_W-1:0] longitude_e5;
	} pos_t;

	logic                 adv;
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	pos_t                 pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic [MW-1:0]        mul_s1;
	logic [SPD_W-1:0]     spd_s1;
	logic [QW-1:0]        hi_s2;
	logic [9:0]           lo_s2;
	logic [HW-1:0]        hif_s3, hif_s4;
	logic [LW-1:0]        lof_s3;
	logic [L2W-1:0]       lom_s4;
	logic [SPD_OUT_W-1:0] spd_s5;

	logic [QW-1:0]        hi_q1;
	logic [SPD_W-1:0]     hi_times_k;

	// The whole pipeline stalls only when its last stage holds an untaken word.
	assign adv = !v_s5 || result.ready;
	assign pop = head_valid && adv;

	// Split the speed into thousands and remainder so each product stays narrow.
	assign hi_q1      = mul_s1[MW-1:RECIP_SHIFT];
	assign hi_times_k = SPD_W'(hi_q1) * SPD_W'(MILLI_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: speed over 1000 by reciprocal multiply.
			pos_s1 <= '{head.fix_active, head.latitude_e5, head.longitude_e5};
			spd_s1 <= head.speed_value;
			mul_s1 <= MW'(head.speed_value[SPD_W-1:3]) * MW'(RECIP_M);
			// Stage 2: quotient and remainder.
			pos_s2 <= pos_s1;
			hi_s2  <= hi_q1;
			lo_s2  <= 10'(spd_s1 - hi_times_k);
			// Stage 3: both parts times the factor.
			pos_s3 <= pos_s2;
			hif_s3 <= HW'(hi_s2) * HW'(factor);
			lof_s3 <= LW'(lo_s2) * LW'(factor);
			// Stage 4: remainder product over 1000.
			pos_s4 <= pos_s3;
			hif_s4 <= hif_s3;
			lom_s4 <= L2W'(lof_s3[LW-1:3]) * L2W'(RECIP_M);
			// Stage 5: sum into the output register.
			pos_s5 <= pos_s4;
			spd_s5 <= SPD_OUT_W'(hif_s4 + HW'(lom_s4[L2W-1:RECIP_SHIFT]));
		end
	end

	assign result.valid           = v_s5;
	assign result.fix_active      = pos_s5.fix_active;
	assign result.latitude_e5     = pos_s5.latitude_e5;
	assign result.longitude_e5    = pos_s5.longitude_e5;
	assign result.speed_milli_kmh = spd_s5;

endmodule

[hw/rtl/nmea_position_speed_extractor.sv]
// Parses NMEA RMC-style sentences one byte per clock: the parser accepts a
// word every cycle as long as the two-entry result queue has room, and only
// stalls input when results pile up because the result channel is not ready.
// A word marked as the end of a sentence yields one result once it leaves the queue
// and passes the five-stage multiply pipeline that scales knots to km/h; results
// stream out at one per cycle while the result channel is ready. Latitude and longitude
// come in units of 1e-5 of the field text, speed in 0.001 km/h. Configuration
// writes take effect on the next cycle and should be made while no sentence
// result is outstanding.
module nmea_position_speed_extractor import nmeaps_pkg::*; #(
	parameter int SENTENCE_LEN = 70,
	parameter int LAT_CHARS = 10,
	parameter int LON_CHARS = 11,
	parameter int SPEED_CHARS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nmeaps_byte_if.sink           sentence,
	nmeaps_result_if.source       result,
	input  logic                  write_enable,
	input  logic [CFG_IDX_W-1:0]  reg_index,
	input  logic [CFG_DATA_W-1:0] write_data
);

	cfg_t   cfg_q;
	logic   push, pop, queue_full, head_valid;
	entry_t push_data, head;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.status_field       <= 5'd2;
			cfg_q.latitude_field     <= 5'd3;
			cfg_q.longitude_field    <= 5'd5;
			cfg_q.speed_field        <= 5'd7;
			cfg_q.active_char        <= 8'd65;
			cfg_q.speed_factor_milli <= 16'd1852;
		end else if (write_enable) begin
			case (reg_index)
				REG_STATUS_FIELD:    cfg_q.status_field       <= write_data[FIELD_W-1:0];
				REG_LATITUDE_FIELD:  cfg_q.latitude_field     <= write_data[FIELD_W-1:0];
				REG_LONGITUDE_FIELD: cfg_q.longitude_field    <= write_data[FIELD_W-1:0];
				REG_SPEED_FIELD:     cfg_q.speed_field        <= write_data[FIELD_W-1:0];
				REG_ACTIVE_CHAR:     cfg_q.active_char        <= write_data[BYTE_W-1:0];
				REG_SPEED_FACTOR:    cfg_q.speed_factor_milli <= write_data[FACTOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nmeaps_front #(
		.SENTENCE_LEN(SENTENCE_LEN),
		.LAT_CHARS(LAT_CHARS),
		.LON_CHARS(LON_CHARS),
		.SPEED_CHARS(SPEED_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sentence(sentence),
		.cfg(cfg_q),
		.queue_full(queue_full),
		.push(push),
		.push_data(push_data)
	);

	nmeaps_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(queue_full),
		.pop(pop),
		.head(head),
		.head_valid(head_valid)
	);

	nmeaps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.factor(cfg_q.speed_factor_milli),
		.pop(pop),
		.result(result)
	);

endmodule

[sim/nmeaps_fix_checker.sv]
// Watches the byte and result channels of the sentence parser, predicts the
// position and speed report for every word that ends a sentence, and compares
// each result word against the oldest report still due.
module nmeaps_fix_checker import nmeaps_pkg::*; #(
	parameter int SENTENCE_LEN = 70,
	parameter int LAT_CHARS = 10,
	parameter int LON_CHARS = 11,
	parameter int SPEED_CHARS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nmeaps_byte_if                sentence,
	nmeaps_result_if              result,
	input  logic                  write_enable,
	input  logic [CFG_IDX_W-1:0]  reg_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	output int                    outstanding,
	output int                    errors
);

	// Number slots: one accumulator per parsed field.
	localparam int SLOT_LAT = 0;
	localparam int SLOT_LON = 1;
	localparam int SLOT_SPD = 2;

	localparam cfg_t CFG_AT_RESET = '{5'd2, 5'd3, 5'd5, 5'd7, 8'h41, 16'd1852};

	typedef struct packed {
		logic                 fix;
		logic [LAT_W-1:0]     lat;
		logic [LON_W-1:0]     lon;
		logic [SPD_OUT_W-1:0] spd;
	} fix_report_t;

	fix_report_t reports_due[$];

	cfg_t               layout;
	logic [FIELD_W-1:0] field_no;
	int unsigned        byte_no;
	logic               fix_flag;
	logic [63:0]        number_acc[3];
	int unsigned        chars_taken[3];
	int unsigned        frac_taken[3];
	bit                 point_seen[3];
	bit                 number_done[3];

	function automatic logic [63:0] ten_to(input int unsigned k);
		logic [63:0] p;
		p = 64'd1;
		repeat (k) p = p * 64'd10;
		return p;
	endfunction

	// A new sentence clears the field position and all numbers, not the fix flag.
	task automatic start_sentence();
		field_no = '0;
		byte_no = 0;
		for (int s = 0; s < 3; s++) begin
			number_acc[s] = '0;
			chars_taken[s] = 0;
			frac_taken[s] = 0;
			point_seen[s] = 1'b0;
			number_done[s] = 1'b0;
		end
	endtask

	// Fold one field character into a fixed-point number, text-to-number style.
	task automatic take_field_char(input int slot, input logic [7:0] ch);
		int unsigned limit;
		int unsigned scale;
		logic [63:0] cap;
		logic [63:0] v;
		logic [63:0] digit;
		limit = (slot == SLOT_LAT) ? LAT_CHARS : (slot == SLOT_LON) ? LON_CHARS : SPEED_CHARS;
		scale = (slot == SLOT_SPD) ? SPD_SCALE : POS_SCALE;
		cap = (slot == SLOT_LAT) ? LAT_CAP : (slot == SLOT_LON) ? LON_CAP : SPD_CAP;
		if (chars_taken[slot] < limit) begin
			chars_taken[slot]++;
			if (!number_done[slot]) begin
				v = number_acc[slot];
				if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
					digit = 64'(ch - CHAR_ZERO);
					if (!point_seen[slot]) begin
						v = v * 64'd10 + digit * ten_to(scale);
					end else if (frac_taken[slot] < scale) begin
						frac_taken[slot]++;
						v = v + digit * ten_to(scale - frac_taken[slot]);
					end
					if (v > cap) v = cap;
					number_acc[slot] = v;
				end else if (ch == CHAR_DOT && !point_seen[slot]) begin
					point_seen[slot] = 1'b1;
				end else begin
					number_done[slot] = 1'b1;
				end
			end
		end
	endtask

	// Advance the parse by one accepted word and queue a report on a sentence end.
	task automatic consume_byte(input logic [7:0] ch, input logic last);
		fix_report_t rep;
		logic [63:0] prod;
		if (ch == CHAR_DOLLAR) begin
			start_sentence();
		end else if (byte_no < SENTENCE_LEN) begin
			byte_no++;
			if (ch == CHAR_COMMA) begin
				if (field_no != FIELD_IDX_MAX) field_no++;
			end else if (field_no == layout.status_field) begin
				fix_flag = (ch == layout.active_char);
			end else if (field_no == layout.latitude_field) begin
				take_field_char(SLOT_LAT, ch);
			end else if (field_no == layout.longitude_field) begin
				take_field_char(SLOT_LON, ch);
			end else if (field_no == layout.speed_field) begin
				take_field_char(SLOT_SPD, ch);
			end
		end
		if (last) begin
			prod = number_acc[SLOT_SPD] * 64'(layout.speed_factor_milli);
			rep.fix = fix_flag;
			rep.lat = number_acc[SLOT_LAT][LAT_W-1:0];
			rep.lon = number_acc[SLOT_LON][LON_W-1:0];
			rep.spd = SPD_OUT_W'(prod / 64'd1000);
			reports_due.push_back(rep);
		end
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_STATUS_FIELD:    layout.status_field = value[FIELD_W-1:0];
			REG_LATITUDE_FIELD:  layout.latitude_field = value[FIELD_W-1:0];
			REG_LONGITUDE_FIELD: layout.longitude_field = value[FIELD_W-1:0];
			REG_SPEED_FIELD:     layout.speed_field = value[FIELD_W-1:0];
			REG_ACTIVE_CHAR:     layout.active_char = value[BYTE_W-1:0];
			REG_SPEED_FACTOR:    layout.speed_factor_milli = value[FACTOR_W-1:0];
			default: ;
		endcase
	endtask

	// Compare one result word with the oldest report due.
	task automatic check_result();
		fix_report_t want;
		if (reports_due.size() == 0) begin
			$error("result word with no sentence end pending");
			errors++;
		end else begin
			want = reports_due.pop_front();
			if (result.fix_active !== want.fix) begin
				$error("fix_active mismatch: expected %0d, got %0d", want.fix, result.fix_active);
				errors++;
			end
			if (result.latitude_e5 !== want.lat) begin
				$error("latitude_e5 mismatch: expected %0d, got %0d", want.lat, result.latitude_e5);
				errors++;
			end
			if (result.longitude_e5 !== want.lon) begin
				$error("longitude_e5 mismatch: expected %0d, got %0d", want.lon,
					result.longitude_e5);
				errors++;
			end
			if (result.speed_milli_kmh !== want.spd) begin
				$error("speed_milli_kmh mismatch: expected %0d, got %0d", want.spd,
					result.speed_milli_kmh);
				errors++;
			end
		end
	endtask

	// Everything is sampled at the rising edge, where the block sees it too.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout = CFG_AT_RESET;
			fix_flag = 1'b0;
			start_sentence();
			reports_due.delete();
			errors = 0;
		end else begin
			if (write_enable) apply_write(reg_index, write_data);
			if (sentence.valid && sentence.ready)
				consume_byte(sentence.data_byte, sentence.end_of_sentence);
			if (result.valid && result.ready) check_result();
		end
		outstanding = reports_due.size();
	end

endmodule

[sim/tb.sv]
// Drives sentences, noise and register settings into the parser and gives
// the verdict from the failure count of the checker.
module tb;
	import nmeaps_pkg::*;

	localparam int SENTENCE_LEN = 70;
	localparam int LAT_CHARS = 10;
	localparam int LON_CHARS = 11;
	localparam int SPEED_CHARS = 5;

	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 240;
	localparam int DRAIN_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int STALL_PERCENT = 30;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_V = 8'h56;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} sentence_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  write_enable;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] write_data;
	int                    errors;
	int                    outstanding;

	sentence_word_t words_q[$];
	int             words_sent;
	int             idle_cycles;
	bit             stall_on;

	// Field layout the sentence builder follows; mirrors the last writes.
	logic [FIELD_W-1:0] st_idx, lat_idx, lon_idx, spd_idx;
	logic [7:0]         act_char;

	nmeaps_byte_if   sentence_ch();
	nmeaps_result_if result_ch();

	nmea_position_speed_extractor #(
		.SENTENCE_LEN(SENTENCE_LEN),
		.LAT_CHARS(LAT_CHARS),
		.LON_CHARS(LON_CHARS),
		.SPEED_CHARS(SPEED_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sentence(sentence_ch),
		.result(result_ch),
		.write_enable(write_enable),
		.reg_index(reg_index),
		.write_data(write_data)
	);

	nmeaps_fix_checker #(
		.SENTENCE_LEN(SENTENCE_LEN),
		.LAT_CHARS(LAT_CHARS),
		.LON_CHARS(LON_CHARS),
		.SPEED_CHARS(SPEED_CHARS)
	) fix_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sentence(sentence_ch),
		.result(result_ch),
		.write_enable(write_enable),
		.reg_index(reg_index),
		.write_data(write_data),
		.outstanding(outstanding),
		.errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The result side stalls at random unless a calm stretch is running.
	always @(negedge clk) begin
		result_ch.ready <= !stall_on || ($urandom_range(99) >= STALL_PERCENT);
	end

	// Give up when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((sentence_ch.valid && sentence_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] any_digit();
		return 8'(CHAR_ZERO + $urandom_range(9));
	endfunction

	// Any byte that does not split fields or restart the sentence; without numeric_ok, also no digit or point.
	function automatic logic [7:0] pick_char(input bit numeric_ok);
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c == CHAR_COMMA || c == CHAR_DOLLAR || (!numeric_ok &&
			((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT)));
		return c;
	endfunction

	task automatic put(input logic [7:0] ch);
		words_q.push_back({ch, 1'b0});
	endtask

	// Number text: empty, overlong, cut short by junk, two points, or plain.
	task automatic put_number();
		case ($urandom_range(9))
			0: ;
			1: repeat ($urandom_range(11, 14)) put(CHAR_NINE);
			2: begin
				repeat ($urandom_range(1, 4)) put(any_digit());
				put(pick_char(1'b0));
				repeat (3) put(any_digit());
			end
			3: begin
				put(any_digit());
				put(CHAR_DOT);
				put(any_digit());
				put(CHAR_DOT);
				repeat (2) put(any_digit());
			end
			default: begin
				repeat ($urandom_range(0, 5)) put(any_digit());
				if ($urandom_range(4) != 0) begin
					put(CHAR_DOT);
					repeat ($urandom_range(0, 8)) put(any_digit());
				end
			end
		endcase
	endtask

	// A well-formed sentence for the current layout, now and then overlong or
	// left without its end mark.
	task automatic put_sentence();
		int top_field;
		int n_fields;
		top_field = st_idx;
		if (lat_idx > top_field) top_field = lat_idx;
		if (lon_idx > top_field) top_field = lon_idx;
		if (spd_idx > top_field) top_field = spd_idx;
		n_fields = top_field + $urandom_range(0, 3);
		put(CHAR_DOLLAR);
		for (int f = 0; f <= n_fields; f++) begin
			if (f != 0) put(CHAR_COMMA);
			if (f == st_idx) begin
				repeat ($urandom_range(1, 2)) put($urandom_range(1) ? act_char : pick_char(1'b1));
			end else if (f == lat_idx || f == lon_idx || f == spd_idx) begin
				put_number();
			end else begin
				repeat ($urandom_range(0, 3)) put(pick_char(1'b1));
			end
		end
		// Overlong tail: commas and junk that run past the length limit.
		if ($urandom_range(9) == 0)
			repeat (40) put($urandom_range(1) ? CHAR_COMMA : pick_char(1'b1));
		if ($urandom_range(19) != 0) words_q[$].last = 1'b1;
	endtask

	task automatic put_noise();
		repeat ($urandom_range(5, 30))
			words_q.push_back({8'($urandom_range(255)), 1'($urandom_range(99) < 8)});
	endtask

	// Offer one word and hold it until the parser takes it.
	task automatic send_word(input sentence_word_t w);
		while (stall_on && $urandom_range(99) < STALL_PERCENT) begin
			sentence_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sentence_ch.valid <= 1'b1;
		sentence_ch.data_byte <= w.ch;
		sentence_ch.end_of_sentence <= w.last;
		@(posedge clk);
		while (!sentence_ch.ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_all();
		while (words_q.size() != 0) send_word(words_q.pop_front());
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= value;
		@(negedge clk);
	endtask

	// Settle the block, then load a new layout; unused high bits carry noise.
	task automatic write_layout(input logic [FIELD_W-1:0] s, la, lo, sp,
		input logic [7:0] ac, input logic [15:0] factor);
		sentence_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		put_reg(REG_STATUS_FIELD, (16'($urandom) & 16'hFFE0) | 16'(s));
		put_reg(REG_LATITUDE_FIELD, (16'($urandom) & 16'hFFE0) | 16'(la));
		put_reg(REG_LONGITUDE_FIELD, (16'($urandom) & 16'hFFE0) | 16'(lo));
		put_reg(REG_SPEED_FIELD, (16'($urandom) & 16'hFFE0) | 16'(sp));
		put_reg(REG_ACTIVE_CHAR, {8'($urandom), ac});
		put_reg(REG_SPEED_FACTOR, factor);
		write_enable <= 1'b0;
		st_idx = s;
		lat_idx = la;
		lon_idx = lo;
		spd_idx = sp;
		act_char = ac;
	endtask

	initial begin
		string opening;
		int target;
		arst_n = 1'b0;
		write_enable = 1'b0;
		reg_index = '0;
		write_data = '0;
		sentence_ch.valid = 1'b0;
		sentence_ch.data_byte = '0;
		sentence_ch.end_of_sentence = 1'b0;
		words_sent = 0;
		stall_on = 1'b1;
		st_idx = 5'd2;
		lat_idx = 5'd3;
		lon_idx = 5'd5;
		spd_idx = 5'd7;
		act_char = CHAR_UPPER_A;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: an end mark before any sentence start, a short complete
		// sentence in the reset layout, an end mark on a start byte, and an
		// all-ones byte that ends an already cleared sentence.
		words_q.push_back({8'h47, 1'b1});
		opening = "$,,A,1.5,,9,,7";
		foreach (opening[i]) put(opening[i]);
		words_q[$].last = 1'b1;
		words_q.push_back({CHAR_DOLLAR, 1'b1});
		words_q.push_back({8'hFF, 1'b1});
		send_all();

		// Random phases, each with its own register setting.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_layout(5'd2, 5'd3, 5'd5, 5'd7, CHAR_UPPER_A, 16'd1852);
				1: write_layout(5'd0, 5'd0, 5'd0, 5'd0, 8'h00, 16'd0);
				2: write_layout(5'd31, 5'd31, 5'd31, 5'd31, 8'hFF, 16'hFFFF);
				3: write_layout(5'd2, 5'd3, 5'd5, 5'd7, CHAR_UPPER_V, 16'hFFFF);
				4: write_layout(5'd1, 5'd2, 5'd4, 5'd6, CHAR_UPPER_A, 16'd1000);
				default: write_layout(5'($urandom_range(9)), 5'($urandom_range(9)),
					5'($urandom_range(9)), 5'($urandom_range(9)),
					$urandom_range(1) ? CHAR_UPPER_A : 8'($urandom_range(255)),
					16'($urandom));
			endcase
			// One whole phase runs without any idling on either side.
			stall_on = (phase != 4);
			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				if ($urandom_range(9) < 7)
					put_sentence();
				else
					put_noise();
				send_all();
			end
		end
		sentence_ch.valid <= 1'b0;

		// Wait for every report, then let the pipeline settle.
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
